// ===== rtl/sbst_pkg.sv =====
// shared constants for the segment versus box slab test
`timescale 1ns / 1ps
package sbst_pkg;
	localparam int COORD_BITS_DEF = 32;
	localparam int EPS_W          = 16;
	localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
	localparam int AXES           = 3;
endpackage

// ===== rtl/sbst_if.sv =====
// segment/box query channel and hit result channel
`timescale 1ns / 1ps
interface sbst_query_if #(parameter int COORD_BITS = 32);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] seg_start_x, seg_start_y, seg_start_z;
	logic signed [COORD_BITS-1:0] seg_end_x, seg_end_y, seg_end_z;
	logic signed [COORD_BITS-1:0] box_low_x, box_low_y, box_low_z;
	logic signed [COORD_BITS-1:0] box_high_x, box_high_y, box_high_z;
	modport source (output valid, seg_start_x, seg_start_y, seg_start_z,
		seg_end_x, seg_end_y, seg_end_z, box_low_x, box_low_y, box_low_z,
		box_high_x, box_high_y, box_high_z, input ready);
	modport sink (input valid, seg_start_x, seg_start_y, seg_start_z,
		seg_end_x, seg_end_y, seg_end_z, box_low_x, box_low_y, box_low_z,
		box_high_x, box_high_y, box_high_z, output ready);
endinterface

interface sbst_result_if;
	logic valid;
	logic ready;
	logic hit;
	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

// ===== rtl/segment_box_slab_test.sv =====
// Exact segment versus axis-aligned box hit test, four-stage pipeline.
// Throughput: one query per cycle; a stage holds only while it is full and the one after holds.
// Stage 3 sets the pace: twelve signed cross products of (COORD_BITS+2)-bit operands in parallel.
// Reset: valid bits clear, eps_q returns to 1.
`timescale 1ns / 1ps
module segment_box_slab_test
	import sbst_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [EPS_W-1:0] cfg_wdata,
	sbst_query_if.sink       query,
	sbst_result_if.source    result
);
	localparam int W1 = COORD_BITS + 1;
	localparam int W2 = COORD_BITS + 2;
	localparam int WP = 2 * W2;

	logic [EPS_W-1:0] eps_q;

	logic signed [COORD_BITS-1:0] s_in [AXES];
	logic signed [COORD_BITS-1:0] e_in [AXES];
	logic signed [COORD_BITS-1:0] l_in [AXES];
	logic signed [COORD_BITS-1:0] h_in [AXES];

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1, en2, en3, en4;

	logic signed [W1-1:0] d_s1  [AXES];
	logic signed [W1-1:0] nl_s1 [AXES];
	logic signed [W1-1:0] nh_s1 [AXES];
	logic [AXES-1:0]      outside_s1;

	logic signed [W2-1:0] lo_s2  [AXES];
	logic signed [W2-1:0] hi_s2  [AXES];
	logic signed [W2-1:0] den_s2 [AXES];
	logic [AXES-1:0]      bnd_s2;
	logic                 miss_s2;

	logic signed [WP-1:0] pa_s3 [AXES][AXES];
	logic signed [WP-1:0] pb_s3 [AXES][AXES];
	logic [AXES-1:0]      bnd_s3;
	logic [AXES-1:0]      rng_ok_s3;
	logic                 miss_s3;

	logic hit_s4;
	logic hit_c;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// per-stage flow control
	assign en4         = !v4_s4 || result.ready;
	assign en3         = !v3_s3 || en4;
	assign en2         = !v2_s2 || en3;
	assign en1         = !v1_s1 || en2;
	assign query.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= query.valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	// gather axes
	always_comb begin
		s_in[0] = query.seg_start_x; s_in[1] = query.seg_start_y; s_in[2] = query.seg_start_z;
		e_in[0] = query.seg_end_x;   e_in[1] = query.seg_end_y;   e_in[2] = query.seg_end_z;
		l_in[0] = query.box_low_x;   l_in[1] = query.box_low_y;   l_in[2] = query.box_low_z;
		h_in[0] = query.box_high_x;  h_in[1] = query.box_high_y;  h_in[2] = query.box_high_z;
	end

	// stage 1: direction and slab offsets, slab membership of the start
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int k = 0; k < AXES; k++) begin
				d_s1[k]       <= W1'(e_in[k]) - W1'(s_in[k]);
				nl_s1[k]      <= W1'(l_in[k]) - W1'(s_in[k]);
				nh_s1[k]      <= W1'(h_in[k]) - W1'(s_in[k]);
				outside_s1[k] <= (s_in[k] < l_in[k]) || (s_in[k] > h_in[k]);
			end
		end
	end

	// stage 2: parallel check, positive denominator, sorted slab ends
	always_ff @(posedge clk) begin
		if (en2) begin
			logic miss;
			miss = 1'b0;
			for (int k = 0; k < AXES; k++) begin
				logic signed [W2-1:0] d, a, b;
				logic [W1-1:0]        m;
				logic                 par;
				d   = W2'(d_s1[k]);
				a   = d_s1[k][W1-1] ? -W2'(nl_s1[k]) : W2'(nl_s1[k]);
				b   = d_s1[k][W1-1] ? -W2'(nh_s1[k]) : W2'(nh_s1[k]);
				m   = d_s1[k][W1-1] ? W1'(-d) : W1'(d);
				par = (m == '0) || (m < W1'(eps_q));
				if (par && outside_s1[k]) miss = 1'b1;
				bnd_s2[k] <= !par;
				den_s2[k] <= W2'({1'b0, m});
				lo_s2[k]  <= (a < b) ? a : b;
				hi_s2[k]  <= (a < b) ? b : a;
			end
			miss_s2 <= miss;
		end
	end

	// stage 3: range against [0,1] and cross products between axes
	always_ff @(posedge clk) begin
		if (en3) begin
			for (int i = 0; i < AXES; i++) begin
				rng_ok_s3[i] <= !bnd_s2[i] ||
					((lo_s2[i] <= den_s2[i]) && !hi_s2[i][W2-1]);
				for (int j = 0; j < AXES; j++) begin
					if (i != j) begin
						pa_s3[i][j] <= WP'(lo_s2[i]) * WP'(den_s2[j]);
						pb_s3[i][j] <= WP'(hi_s2[j]) * WP'(den_s2[i]);
					end
				end
			end
			bnd_s3  <= bnd_s2;
			miss_s3 <= miss_s2;
		end
	end

	// stage 4: no parallel miss, every range ok, and every lower end must not pass any other upper end
	always_comb begin
		hit_c = !miss_s3 && (&rng_ok_s3);
		for (int i = 0; i < AXES; i++) begin
			for (int j = 0; j < AXES; j++) begin
				if (i != j && bnd_s3[i] && bnd_s3[j] && (pa_s3[i][j] > pb_s3[i][j]))
					hit_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			hit_s4 <= hit_c;
		end
	end

	assign result.valid = v4_s4;
	assign result.hit   = hit_s4;
endmodule

// ===== tb/segment_box_slab_test_tb.sv =====
// testbench for the segment versus box slab test: directed and random queries
`timescale 1ns / 1ps
module testbench;
	import sbst_pkg::*;

	localparam int CW = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct {
		coord_t s[3];
		coord_t e[3];
		coord_t lo[3];
		coord_t hi[3];
	} query_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [EPS_W-1:0] cfg_wdata;

	sbst_query_if #(.COORD_BITS(CW)) query ();
	sbst_result_if result ();

	segment_box_slab_test #(.COORD_BITS(CW)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.query(query), .result(result)
	);

	logic [EPS_W-1:0] eps_model;
	bit hit_queue[$];
	int errors;
	int idle_cycles;
	bit timed_out;
	bit sink_bursty;
	int sink_hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// exact comparison a*b <= c*d on wide signed products
	function automatic bit prod_le(logic signed [63:0] a, logic signed [63:0] b,
		logic signed [63:0] c, logic signed [63:0] d);
		logic signed [127:0] x, y;
		x = 128'(a) * 128'(b);
		y = 128'(c) * 128'(d);
		return x <= y;
	endfunction

	// expected hit flag for one query under the current epsilon
	function automatic bit predict_hit(query_t q);
		logic signed [63:0] nlo[3], nhi[3], den[3];
		logic signed [63:0] s, d, nl, nh, m;
		bit bnd[3];
		bit h;
		h = 1'b1;
		for (int k = 0; k < 3; k++) begin
			s = 64'(q.s[k]);
			d = 64'(q.e[k]) - s;
			nl = 64'(q.lo[k]) - s;
			nh = 64'(q.hi[k]) - s;
			m = d < 0 ? -d : d;
			bnd[k] = 1'b0;
			nlo[k] = 0; nhi[k] = 0; den[k] = 1;
			if (m == 0 || m < 64'(eps_model)) begin
				if (q.s[k] < q.lo[k] || q.s[k] > q.hi[k]) h = 1'b0;
			end else begin
				if (d < 0) begin
					d = -d; nl = -nl; nh = -nh;
				end
				bnd[k] = 1'b1;
				nlo[k] = nl < nh ? nl : nh;
				nhi[k] = nl < nh ? nh : nl;
				den[k] = d;
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (h && bnd[i]) begin
				if (nlo[i] > den[i] || nhi[i] < 0) h = 1'b0;
				for (int j = 0; j < 3; j++)
					if (h && j != i && bnd[j] && !prod_le(nlo[i], den[j], nhi[j], den[i]))
						h = 1'b0;
			end
		end
		return h;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// send one query, record its expected result; valid stays up for back-to-back transfers
	task automatic send_query(query_t q);
		int g;
		g = gap_len();
		if (g > 0) begin
			query.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		query.valid <= 1'b1;
		query.seg_start_x <= q.s[0]; query.seg_start_y <= q.s[1]; query.seg_start_z <= q.s[2];
		query.seg_end_x <= q.e[0]; query.seg_end_y <= q.e[1]; query.seg_end_z <= q.e[2];
		query.box_low_x <= q.lo[0]; query.box_low_y <= q.lo[1]; query.box_low_z <= q.lo[2];
		query.box_high_x <= q.hi[0]; query.box_high_y <= q.hi[1];
		query.box_high_z <= q.hi[2];
		@(posedge clk);
		while (!query.ready) @(posedge clk);
		hit_queue.push_back(predict_hit(q));
	endtask

	// result check on each transfer
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (hit_queue.size() == 0)
				report_mismatch("result with nothing expected");
			else begin
				bit exp_hit;
				exp_hit = hit_queue.pop_front();
				if (result.hit !== exp_hit)
					report_mismatch($sformatf("hit %b, expected %b", result.hit, exp_hit));
			end
		end
	end

	// result ready stalls: stall-free stretches, short random stalls, a few long ones
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) sink_bursty <= ~sink_bursty;
		if (sink_hold > 0) begin
			result.ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if ($urandom_range(0, 99) < 2) begin
			result.ready <= 1'b0;
			sink_hold <= $urandom_range(8, 30);
		end else if (!sink_bursty) begin
			result.ready <= 1'b1;
		end else begin
			result.ready <= ($urandom_range(0, 9) < 6);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((query.valid && query.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			timed_out = 1'b1;
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic drain();
		query.valid <= 1'b0;
		while (hit_queue.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_epsilon(logic [EPS_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		eps_model = v;
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return coord_t'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
		endcase
	endfunction

	function automatic query_t rand_query();
		query_t q;
		int mode;
		mode = $urandom_range(0, 9);
		for (int k = 0; k < 3; k++) begin
			q.lo[k] = coord_t'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			q.hi[k] = q.lo[k] + coord_t'($urandom_range(0, 6 << 16));
			q.s[k] = rand_coord();
			q.e[k] = rand_coord();
			// near-parallel directions and shared coordinates
			if ($urandom_range(0, 5) == 0)
				q.e[k] = q.s[k] + coord_t'($signed($urandom_range(0, 8)) - 4);
			if (mode == 0) begin
				q.lo[k] = rand_coord(); q.hi[k] = rand_coord();
			end
			if (mode == 1) q.e[k] = q.s[k];
		end
		return q;
	endfunction

	function automatic query_t make_query(coord_t sv, coord_t ev, coord_t lv, coord_t hv);
		query_t q;
		for (int k = 0; k < 3; k++) begin
			q.s[k] = sv; q.e[k] = ev; q.lo[k] = lv; q.hi[k] = hv;
		end
		return q;
	endfunction

	// extremes, degenerate segments, inverted boxes, parallel axes
	task automatic test_directed();
		query_t q;
		send_query(make_query(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		send_query(make_query(32'sh7fffffff, 32'sh80000000, 0, 0));
		send_query(make_query(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
		send_query(make_query(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		send_query(make_query(32'sh10000, 32'sh10000, 0, 32'sh20000));
		send_query(make_query(32'sh30000, 32'sh30000, 0, 32'sh20000));
		send_query(make_query(-32'sh10000, 32'sh30000, 32'sh20000, 0));
		send_query(make_query(-32'sh10000, 32'sh30000, 0, 32'sh20000));
		send_query(make_query(0, 32'sh20000, 32'sh20000, 32'sh30000));
		send_query(make_query(0, 32'sh1ffff, 32'sh20000, 32'sh30000));
		send_query(make_query(32'sh30000, 0, 32'sh10000, 32'sh10000));
		q = make_query(0, 32'sh10000, 32'sh8000, 32'sh9000);
		q.e[1] = 1; q.e[2] = -1;
		send_query(q);
		q.s[2] = 32'sh20000; q.e[2] = 32'sh20000;
		send_query(q);
		q = make_query(0, 32'sh40000, 32'sh10000, 32'sh20000);
		q.e[1] = 32'sh10000; q.lo[1] = 32'sh3000; q.hi[1] = 32'sh3800;
		send_query(q);
		q = make_query(32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff);
		send_query(q);
		q = make_query(32'sh55555555, 32'shaaaaaaaa, 32'shaaaaaaaa, 32'sh55555555);
		send_query(q);
		drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) send_query(rand_query());
		drain();
	endtask

	// epsilon sweep including both extremes
	task automatic test_epsilon_settings();
		logic [EPS_W-1:0] vals[5];
		vals = '{16'd0, 16'hffff, 16'd4, 16'h8000, 16'd1};
		foreach (vals[i]) begin
			write_epsilon(vals[i]);
			test_directed();
			test_random(100);
		end
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		sink_bursty = 1'b0;
		sink_hold = 0;
		eps_model = EPS_RESET;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		result.ready = 1'b0;
		query.valid = 1'b0;
		{query.seg_start_x, query.seg_start_y, query.seg_start_z} = '0;
		{query.seg_end_x, query.seg_end_y, query.seg_end_z} = '0;
		{query.box_low_x, query.box_low_y, query.box_low_z} = '0;
		{query.box_high_x, query.box_high_y, query.box_high_z} = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(80);
		test_epsilon_settings();
		drain();
		if (errors == 0 && !timed_out)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/sbst_pkg.sv
rtl/sbst_if.sv
rtl/segment_box_slab_test.sv
tb/segment_box_slab_test_tb.sv
